// ===== hw/rtl/oblivious_bucket_shuffle_macros.svh =====
// assertion macros for the bucket shuffle
`ifndef OBLIVIOUS_BUCKET_SHUFFLE_MACROS_SVH
`define OBLIVIOUS_BUCKET_SHUFFLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define OBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define OBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/obs_pkg.sv =====
// shared constants and types of the bucket shuffle
`timescale 1ns / 1ps
package obs_pkg;
  localparam int SIDE_MAX_DEF = 8;
  localparam int PAD_MAX_DEF  = 16;
  localparam int KEY_W        = 6;
  localparam int VAL_W        = 32;
  localparam int SIDE_CFG_W   = 4;
  localparam int PAD_CFG_W    = 5;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int PERM_MIN     = 64;

  localparam logic [SIDE_CFG_W-1:0] SIDE_RST = SIDE_CFG_W'(8);
  localparam logic [PAD_CFG_W-1:0]  PAD_RST  = PAD_CFG_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUCKET_SIDE = 1'b0,
    REG_PAD_LIMIT   = 1'b1
  } cfg_reg_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_D_RDE = 10'b0000000010,
    ST_D_RDP = 10'b0000000100,
    ST_D_TGT = 10'b0000001000,
    ST_D_DIV = 10'b0000010000,
    ST_D_PUT = 10'b0000100000,
    ST_D_PAD = 10'b0001000000,
    ST_C_RD  = 10'b0010000000,
    ST_C_WR  = 10'b0100000000,
    ST_C_OUT = 10'b1000000000
  } dist_state_t;
endpackage

// ===== hw/rtl/obs_ram.sv =====
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module obs_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/oblivious_bucket_shuffle.sv =====
// loading takes one item per clock while busy is low; the closing item (in_last_item,
// or the side*side-th item) starts a run: each input bucket is distributed into the
// temp store, then each temp bucket is cleaned up and gives side results, one per clock
// the temp ram has a single port each way, and target/side is a repeated subtraction
// busy stays high for the whole run; results come as one-cycle out_valid strobes
// rst_n (synchronous) clears control state and config; the stores stay undefined
`timescale 1ns / 1ps
`include "oblivious_bucket_shuffle_macros.svh"
module oblivious_bucket_shuffle
  import obs_pkg::*;
#(
  parameter int SIDE_MAX = SIDE_MAX_DEF,
  parameter int PAD_MAX  = PAD_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [KEY_W-1:0]        in_elem_key,
  input  logic signed [VAL_W-1:0] in_elem_value,
  input  logic [KEY_W-1:0]        in_perm_target,
  input  logic                    in_last_item,
  output logic                    out_valid,
  output logic [KEY_W-1:0]        out_key,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last,
  output logic                    out_overflow,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);
  localparam int ELEM_DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int PERM_DEPTH = (ELEM_DEPTH > PERM_MIN) ? ELEM_DEPTH : PERM_MIN;
  localparam int TEMP_DEPTH = ELEM_DEPTH * PAD_MAX;
  localparam int EAW = (ELEM_DEPTH > 1) ? $clog2(ELEM_DEPTH) : 1;
  localparam int PAW = $clog2(PERM_DEPTH);
  localparam int TAW = (TEMP_DEPTH > 1) ? $clog2(TEMP_DEPTH) : 1;
  localparam int SW  = $clog2(SIDE_MAX + 1);
  localparam int BW  = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1;
  localparam int NW  = $clog2(ELEM_DEPTH + 1);
  localparam int CW  = $clog2(PAD_MAX + 1);
  localparam int EW  = KEY_W + VAL_W;
  localparam int TW  = 1 + BW + EW;

  function automatic logic [TAW-1:0] tidx(input int a, input int b, input int c);
    return TAW'((a * SIDE_MAX + b) * PAD_MAX + c);
  endfunction

  dist_state_t state_r, state_nxt;
  logic [SIDE_CFG_W-1:0] cfg_side_r;
  logic [PAD_CFG_W-1:0]  cfg_pad_r;
  logic [SW-1:0] side_r, side_nxt, side_eff;
  logic [CW-1:0] pad_r, pad_nxt, pad_eff;
  logic [NW-1:0] n_r, n_nxt, n_eff;
  logic [NW-1:0] load_cnt_r, load_cnt_nxt;
  logic [BW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [EAW-1:0] ep_r, ep_nxt;
  logic [KEY_W-1:0] rem_r, rem_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic ovf_r, ovf_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_last_r, out_last_nxt, out_ovf_r, out_ovf_nxt;
  logic [EW-1:0] out_elem_r, out_elem_nxt;
  logic [CW-1:0] cnt_r [SIDE_MAX];
  logic [EW-1:0] bb_r [SIDE_MAX];

  logic in_accept, go_run, cnt_clr, cnt_inc, cnt_ok, bb_we;
  logic last_i, last_j, last_k, last_s;
  logic [BW-1:0] bb_idx;
  logic [EW-1:0] bb_wdata;
  logic [EW-1:0] elem_rdata;
  logic [KEY_W-1:0] perm_rdata;
  logic temp_we;
  logic [TW-1:0] temp_wdata, temp_rdata;
  logic [TAW-1:0] temp_waddr, temp_raddr;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_side_r <= SIDE_RST;
      cfg_pad_r  <= PAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BUCKET_SIDE: cfg_side_r <= cfg_wdata[SIDE_CFG_W-1:0];
        REG_PAD_LIMIT:   cfg_pad_r  <= cfg_wdata[PAD_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  always_comb begin
    if (cfg_side_r == '0) side_eff = SW'(1);
    else if (int'(cfg_side_r) > SIDE_MAX) side_eff = SW'(SIDE_MAX);
    else side_eff = SW'(cfg_side_r);
    if (cfg_pad_r == '0) pad_eff = CW'(1);
    else if (int'(cfg_pad_r) > PAD_MAX) pad_eff = CW'(PAD_MAX);
    else pad_eff = CW'(cfg_pad_r);
    n_eff = NW'(int'(side_eff) * int'(side_eff));
  end

  assign busy      = (state_r != ST_IDLE);
  assign in_accept = start && !busy;
  assign go_run    = in_last_item || (int'(load_cnt_r) + 1 >= int'(n_eff));

  obs_ram #(.W(EW), .D(ELEM_DEPTH)) u_elem (
    .clk(clk), .we(in_accept), .waddr(load_cnt_r[EAW-1:0]),
    .wdata({in_elem_key, in_elem_value}), .raddr(ep_r), .rdata(elem_rdata)
  );

  obs_ram #(.W(KEY_W), .D(PERM_DEPTH)) u_perm (
    .clk(clk), .we(in_accept), .waddr(PAW'(load_cnt_r)), .wdata(in_perm_target),
    .raddr(PAW'(elem_rdata[EW-1:VAL_W])), .rdata(perm_rdata)
  );

  obs_ram #(.W(TW), .D(TEMP_DEPTH)) u_temp (
    .clk(clk), .we(temp_we), .waddr(temp_waddr), .wdata(temp_wdata),
    .raddr(temp_raddr), .rdata(temp_rdata)
  );

  assign cnt_ok     = (cnt_r[k_r] < pad_r);
  assign temp_we    = cnt_ok && ((state_r == ST_D_PUT) || (state_r == ST_D_PAD));
  assign temp_waddr = tidx(int'(k_r), int'(i_r), int'(cnt_r[k_r]));
  assign temp_wdata = (state_r == ST_D_PAD) ? {1'b1, {(TW-1){1'b0}}}
                                            : {1'b0, BW'(rem_r), e_r};
  assign temp_raddr = tidx(int'(i_r), int'(j_r), int'(s_r));

  assign last_i = (int'(i_r) == int'(side_r) - 1);
  assign last_j = (int'(j_r) == int'(side_r) - 1);
  assign last_k = (int'(k_r) == int'(side_r) - 1);
  assign last_s = (int'(s_r) == int'(pad_r) - 1);

  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    pad_nxt       = pad_r;
    n_nxt         = n_r;
    load_cnt_nxt  = load_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    ep_nxt        = ep_r;
    rem_nxt       = rem_r;
    e_nxt         = e_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_elem_nxt  = out_elem_r;
    cnt_clr       = 1'b0;
    cnt_inc       = 1'b0;
    bb_we         = 1'b0;
    bb_idx        = j_r;
    bb_wdata      = elem_rdata;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (go_run) begin
            load_cnt_nxt = '0;
            side_nxt     = side_eff;
            pad_nxt      = pad_eff;
            n_nxt        = n_eff;
            ovf_nxt      = 1'b0;
            i_nxt        = '0;
            j_nxt        = '0;
            ep_nxt       = '0;
            cnt_clr      = 1'b1;
            state_nxt    = ST_D_RDE;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      ST_D_RDE: state_nxt = ST_D_RDP;
      ST_D_RDP: begin
        // the buffer ends up holding the last input bucket
        bb_we     = 1'b1;
        e_nxt     = elem_rdata;
        state_nxt = ST_D_TGT;
      end
      ST_D_TGT: begin
        if (int'(perm_rdata) >= int'(n_r)) begin
          ep_nxt = ep_r + 1'b1;
          if (last_j) begin
            k_nxt     = '0;
            state_nxt = ST_D_PAD;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_D_RDE;
          end
        end else begin
          rem_nxt   = perm_rdata;
          k_nxt     = '0;
          state_nxt = ST_D_DIV;
        end
      end
      ST_D_DIV: begin
        // target / side by repeated subtraction
        if (int'(rem_r) >= int'(side_r)) begin
          rem_nxt = rem_r - KEY_W'(side_r);
          k_nxt   = k_r + 1'b1;
        end else begin
          state_nxt = ST_D_PUT;
        end
      end
      ST_D_PUT: begin
        if (cnt_ok) cnt_inc = 1'b1;
        else ovf_nxt = 1'b1;
        ep_nxt = ep_r + 1'b1;
        if (last_j) begin
          k_nxt     = '0;
          state_nxt = ST_D_PAD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_D_RDE;
        end
      end
      ST_D_PAD: begin
        if (cnt_ok) begin
          cnt_inc = 1'b1;
        end else if (last_k) begin
          j_nxt = '0;
          if (last_i) begin
            i_nxt     = '0;
            s_nxt     = '0;
            state_nxt = ST_C_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            cnt_clr   = 1'b1;
            state_nxt = ST_D_RDE;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_C_RD: state_nxt = ST_C_WR;
      ST_C_WR: begin
        if (!temp_rdata[TW-1]) begin
          bb_we    = 1'b1;
          bb_idx   = temp_rdata[EW +: BW];
          bb_wdata = temp_rdata[EW-1:0];
        end
        if (last_s) begin
          s_nxt = '0;
          if (last_j) begin
            j_nxt     = '0;
            state_nxt = ST_C_OUT;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_C_RD;
          end
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_C_RD;
        end
      end
      ST_C_OUT: begin
        out_valid_nxt = 1'b1;
        out_elem_nxt  = bb_r[j_r];
        out_last_nxt  = last_i && last_j;
        out_ovf_nxt   = ovf_r;
        if (last_j) begin
          j_nxt = '0;
          if (last_i) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            s_nxt     = '0;
            state_nxt = ST_C_RD;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      side_r      <= '0;
      pad_r       <= '0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      s_r         <= '0;
      ep_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      side_r      <= side_nxt;
      pad_r       <= pad_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      s_r         <= s_nxt;
      ep_r        <= ep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    e_r        <= e_nxt;
    out_elem_r <= out_elem_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
    if (bb_we) begin
      bb_r[bb_idx] <= bb_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cnt_clr) begin
      for (int q = 0; q < SIDE_MAX; q++) begin
        cnt_r[q] <= '0;
      end
    end else if (cnt_inc) begin
      cnt_r[k_r] <= cnt_r[k_r] + 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key      = out_elem_r[EW-1:VAL_W];
  assign out_value    = out_elem_r[VAL_W-1:0];
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  `OBS_ASSERT_IMPL(a_quot_bound, (state_r == ST_D_DIV), (int'(k_r) < int'(side_r)), "quotient past side")
  `OBS_ASSERT_IMPL(a_temp_wr_fits, temp_we, (cnt_r[k_r] < pad_r), "temp write past pad limit")
  `OBS_ASSERT_NEXT(a_emit_strobe, (state_r == ST_C_OUT), out_valid_r, "missing result strobe")
endmodule

// ===== sim/shuffle_order_check.sv =====
// watches the shuffle channels, predicts the shuffled order and compares results
`timescale 1ns / 1ps
module shuffle_order_check
  import obs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [KEY_W-1:0]        in_elem_key,
  input  logic signed [VAL_W-1:0] in_elem_value,
  input  logic [KEY_W-1:0]        in_perm_target,
  input  logic                    in_last_item,
  input  logic                    out_valid,
  input  logic [KEY_W-1:0]        out_key,
  input  logic signed [VAL_W-1:0] out_value,
  input  logic                    out_last,
  input  logic                    out_overflow,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output int                      errors,
  output int                      pending,
  output int                      results_seen,
  output int                      overflow_runs
);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             dummy;
  } slot_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             ovf;
  } shuffled_t;

  logic [SIDE_CFG_W-1:0] side_reg;
  logic [PAD_CFG_W-1:0]  pad_reg;
  logic [KEY_W-1:0]      perm_mem[64];
  slot_t                 elem_mem[64];
  slot_t                 temp_mem[SIDE_MAX_DEF*SIDE_MAX_DEF*PAD_MAX_DEF];
  slot_t                 bkt_buf[SIDE_MAX_DEF];
  int unsigned           load_cnt;
  bit                    ovf_seen;
  shuffled_t             shuffled_q[$];

  assign pending = shuffled_q.size();

  function automatic int tidx(int k, int i, int s);
    return (k * SIDE_MAX_DEF + i) * PAD_MAX_DEF + s;
  endfunction

  // distribution then cleanup, results pushed in output order
  task automatic shuffle_run(int side, int pad);
    int n;
    int cnt;
    int k;
    int tgt;
    int sub_cnt[SIDE_MAX_DEF];
    slot_t e;
    shuffled_t r;
    n = side * side;
    ovf_seen = 0;
    for (int i = 0; i < side; i++) begin
      for (k = 0; k < side; k++) sub_cnt[k] = 0;
      for (int j = 0; j < side; j++) begin
        e = elem_mem[i*side + j];
        tgt = perm_mem[e.key];
        bkt_buf[j] = e;
        if (tgt >= n) continue;
        k = tgt / side;
        if (sub_cnt[k] >= pad) begin
          ovf_seen = 1;
          continue;
        end
        temp_mem[tidx(k, i, sub_cnt[k])] = e;
        sub_cnt[k]++;
      end
      for (k = 0; k < side; k++)
        for (int s = sub_cnt[k]; s < pad; s++) temp_mem[tidx(k, i, s)] = '{0, 0, 1'b1};
    end
    cnt = 0;
    for (int i = 0; i < side; i++) begin
      for (int j = 0; j < side; j++)
        for (int s = 0; s < pad; s++) begin
          e = temp_mem[tidx(i, j, s)];
          if (e.dummy) continue;
          bkt_buf[perm_mem[e.key] % side] = e;
        end
      for (int m = 0; m < side; m++) begin
        r.key   = bkt_buf[m].key;
        r.value = bkt_buf[m].value;
        r.last  = (cnt + 1 == n);
        r.ovf   = ovf_seen;
        shuffled_q.push_back(r);
        cnt++;
      end
    end
  endtask

  task automatic load_element();
    int side;
    int pad;
    int pos;
    side = (side_reg < 1) ? 1 : (side_reg > SIDE_MAX_DEF) ? SIDE_MAX_DEF : side_reg;
    pad  = (pad_reg < 1) ? 1 : (pad_reg > PAD_MAX_DEF) ? PAD_MAX_DEF : pad_reg;
    pos  = load_cnt;
    elem_mem[pos] = '{in_elem_key, in_elem_value, 1'b0};
    perm_mem[pos] = in_perm_target;
    if (!in_last_item && pos + 1 < side * side) begin
      load_cnt = pos + 1;
    end else begin
      load_cnt = 0;
      shuffle_run(side, pad);
    end
  endtask

  task automatic compare_result();
    shuffled_t x;
    results_seen++;
    if (shuffled_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result key %0d value %0d", out_key, out_value);
    end else begin
      x = shuffled_q.pop_front();
      if (x.last && x.ovf) overflow_runs++;
      if (out_key !== x.key || out_value !== x.value || out_last !== x.last ||
          out_overflow !== x.ovf) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected key %0d value %0d last %0d ovf %0d, got %0d %0d %0d %0d",
                   x.key, $signed(x.value), x.last, x.ovf,
                   out_key, out_value, out_last, out_overflow);
      end
    end
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    overflow_runs = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      side_reg = SIDE_RST;
      pad_reg  = PAD_RST;
      load_cnt = 0;
      ovf_seen = 0;
      shuffled_q.delete();
    end else begin
      if (out_valid) compare_result();
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == REG_BUCKET_SIDE) side_reg = cfg_wdata[SIDE_CFG_W-1:0];
        else pad_reg = cfg_wdata[PAD_CFG_W-1:0];
      end
      if (start && !busy) load_element();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// stimulus and verdict for the bucket shuffle testbench
`timescale 1ns / 1ps
module tb_top;
  import obs_pkg::*;

  logic                    clk = 0;
  logic                    rst_n = 0;
  logic                    start = 0;
  logic                    busy;
  logic [KEY_W-1:0]        in_elem_key = 0;
  logic signed [VAL_W-1:0] in_elem_value = 0;
  logic [KEY_W-1:0]        in_perm_target = 0;
  logic                    in_last_item = 0;
  logic                    out_valid;
  logic [KEY_W-1:0]        out_key;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_last;
  logic                    out_overflow;
  logic                    cfg_we = 0;
  logic [CFG_IDX_W-1:0]    cfg_index = 0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = 0;
  int                      errors, pending, results_seen, overflow_runs;

  int items_sent = 0;
  int side_now = 8;
  bit no_gaps = 0;
  int perm[64];

  oblivious_bucket_shuffle u_dut (.*);

  shuffle_order_check u_order_check (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(int key, logic [31:0] val, int tgt, bit last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      start = 0;
      repeat (g) @(negedge clk);
    end
    in_elem_key = KEY_W'(key);
    in_elem_value = val;
    in_perm_target = KEY_W'(tgt);
    in_last_item = last;
    start = 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
      @(negedge clk);
    end
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    start = 0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we = 0;
    if (idx == REG_BUCKET_SIDE) begin
      side_now = val & 15;
      if (side_now < 1) side_now = 1;
      if (side_now > SIDE_MAX_DEF) side_now = SIDE_MAX_DEF;
    end
  endtask

  task automatic shuffle_perm(int n);
    int j, t;
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
  endtask

  // one loading sequence; kind selects well-formed or broken flavors
  task automatic run_set(int kind);
    int n, stop;
    n = side_now * side_now;
    shuffle_perm(n);
    stop = (kind == 2) ? $urandom_range(0, n - 1) : n - 1;
    for (int p = 0; p <= stop; p++) begin
      case (kind)
        1: send($urandom_range(0, 63), $urandom, $urandom_range(0, 63), p == stop);
        3: send(p, $urandom, perm[p], 1'b0);
        4: send(p, $urandom, $urandom_range(0, n - 1), p == stop);
        default: send(p, $urandom, perm[p], p == stop);
      endcase
    end
    wait_idle();
  endtask

  initial begin
    int r;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // full load of all positions so every later read hits written entries
    write_reg(REG_BUCKET_SIDE, 8);
    write_reg(REG_PAD_LIMIT, 16);
    run_set(0);

    // single element runs, extreme values, full load with no last flag
    write_reg(REG_BUCKET_SIDE, 1);
    write_reg(REG_PAD_LIMIT, 1);
    send(0, 32'h7fffffff, 0, 1'b1);
    send(63, 32'h80000000, 63, 1'b0);
    wait_idle();
    // overflow: two elements of one input bucket head to temp bucket zero
    write_reg(REG_BUCKET_SIDE, 2);
    send(0, 32'hffffffff, 0, 1'b0);
    send(1, 32'h00000000, 1, 1'b0);
    send(2, 32'h12345678, 3, 1'b0);
    send(3, 32'h80000001, 2, 1'b1);
    wait_idle();
    // duplicate targets and an early last item
    write_reg(REG_PAD_LIMIT, 16);
    send(0, 32'h1, 3, 1'b0);
    send(1, 32'h2, 3, 1'b0);
    send(2, 32'h3, 0, 1'b1);
    wait_idle();
    // out of range register values clamp
    write_reg(REG_BUCKET_SIDE, 0);
    write_reg(REG_PAD_LIMIT, 0);
    send(0, 32'h55aa55aa, 0, 1'b1);
    wait_idle();
    write_reg(REG_BUCKET_SIDE, 15);
    write_reg(REG_PAD_LIMIT, 31);
    run_set(1);

    while (items_sent < 160) begin
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 9);
        write_reg(REG_BUCKET_SIDE, r < 7 ? $urandom_range(1, 4) :
                  r < 9 ? $urandom_range(5, 8) : $urandom_range(0, 15));
        r = $urandom_range(0, 9);
        write_reg(REG_PAD_LIMIT, r < 8 ? $urandom_range(1, 16) : $urandom_range(0, 31));
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      run_set(r < 6 ? 0 : r - 5);
    end
    no_gaps = 0;
    wait_idle();
    repeat (50) @(negedge clk);

    $display("ran %0d items, checked %0d shuffled results, %0d runs with overflow",
             items_sent, results_seen, overflow_runs);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
